// ===== sv/rles_pkg.sv =====
// Shared types and constants for the RGB LED effect sequencer.
package rles_pkg;

    // Default width of the blink period store and the tick counter
    localparam int unsigned PERIOD_BITS_DEF = 16;

    // Input field and configuration widths
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned BPER_W   = 16;
    localparam int unsigned STEP_W   = 8;
    localparam int unsigned INTV_W   = 10;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 10;

    // Item mode codes
    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STATIC = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BLINK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BREATH = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_STEP     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_INTERVAL = 1'b1;

    // Configuration reset values
    localparam logic [STEP_W-1:0] BREATH_STEP_RST     = 8'd5;
    localparam logic [INTV_W-1:0] BREATH_INTERVAL_RST = 10'd20;

    // Refresh job handed from the front end to the back end.
    // breath = 0: red/green/blue go out as they are.
    // breath = 1: colour is scaled by the gamma of level.
    typedef struct packed {
        logic              breath;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] level;
    } t_job;

endpackage

// ===== sv/rles_front.sv =====
// Front end: takes items, keeps effect state and tick counting, issues refresh jobs.
module rles_front #(
    parameter int unsigned PERIOD_BITS = rles_pkg::PERIOD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [rles_pkg::MODE_W-1:0]     i_mode,
    input  logic [rles_pkg::CHAN_W-1:0]     i_red,
    input  logic [rles_pkg::CHAN_W-1:0]     i_green,
    input  logic [rles_pkg::CHAN_W-1:0]     i_blue,
    input  logic [rles_pkg::BPER_W-1:0]     i_blink_period,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [rles_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rles_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    // job queue push side
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output rles_pkg::t_job                  o_q_job
);

    localparam int unsigned CW = (PERIOD_BITS > rles_pkg::INTV_W) ?
                                 PERIOD_BITS : rles_pkg::INTV_W;
    localparam logic [PERIOD_BITS-1:0] CNT_MAX = {PERIOD_BITS{1'b1}};

    typedef enum logic [1:0] {
        ACT_OFF    = 2'd0,
        ACT_STATIC = 2'd1,
        ACT_BLINK  = 2'd2,
        ACT_BREATH = 2'd3
    } t_active;

    // effect state
    t_active                       r_active,  n_active;
    logic [rles_pkg::CHAN_W-1:0]   r_red,     n_red;
    logic [rles_pkg::CHAN_W-1:0]   r_green,   n_green;
    logic [rles_pkg::CHAN_W-1:0]   r_blue,    n_blue;
    logic [PERIOD_BITS-1:0]        r_period,  n_period;
    logic                          r_phase,   n_phase;
    logic [rles_pkg::CHAN_W-1:0]   r_level,   n_level;
    logic                          r_falling, n_falling;
    logic [PERIOD_BITS-1:0]        r_tick,    n_tick;
    // configuration
    logic [rles_pkg::STEP_W-1:0]   r_breath_step;
    logic [rles_pkg::INTV_W-1:0]   r_breath_interval;

    // effective state that a refresh works from
    t_active                       e_active;
    logic                          e_phase;
    logic [rles_pkg::CHAN_W-1:0]   e_level;
    logic                          e_falling;

    logic                          accept;
    logic                          is_cmd;
    logic                          do_refresh;
    logic [PERIOD_BITS-1:0]        cnt_inc;
    logic [CW-1:0]                 target;
    logic [rles_pkg::CHAN_W:0]     sum;
    logic [rles_pkg::CHAN_W-1:0]   br_level;
    logic                          br_falling;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign is_cmd     = (i_mode >= rles_pkg::MODE_OFF) && (i_mode <= rles_pkg::MODE_BREATH);

    // saturating tick count and the target it is compared against
    assign cnt_inc = (r_tick == CNT_MAX) ? r_tick : r_tick + 1'b1;
    assign target  = (r_active == ACT_BLINK) ? CW'(r_period) : CW'(r_breath_interval);

    // triangle level update, clamped to 0..255
    assign sum = {1'b0, e_level} + {1'b0, r_breath_step};
    always_comb begin
        if (e_falling) begin
            if (e_level <= r_breath_step) begin
                br_level   = '0;
                br_falling = 1'b0;
            end else begin
                br_level   = e_level - r_breath_step;
                br_falling = 1'b1;
            end
        end else begin
            if (sum >= 9'd255) begin
                br_level   = 8'd255;
                br_falling = 1'b1;
            end else begin
                br_level   = sum[rles_pkg::CHAN_W-1:0];
                br_falling = 1'b0;
            end
        end
    end

    // item decode and state update
    always_comb begin
        n_active   = r_active;
        n_red      = r_red;
        n_green    = r_green;
        n_blue     = r_blue;
        n_period   = r_period;
        n_phase    = r_phase;
        n_level    = r_level;
        n_falling  = r_falling;
        n_tick     = r_tick;
        e_active   = r_active;
        e_phase    = r_phase;
        e_level    = r_level;
        e_falling  = r_falling;
        do_refresh = 1'b0;
        o_q_job    = '0;

        if (accept && is_cmd) begin
            // command: store fields, restart the effect, refresh at once
            e_active   = t_active'(i_mode[1:0] - 2'd1);
            e_phase    = 1'b0;
            e_level    = '0;
            e_falling  = 1'b0;
            n_active   = e_active;
            n_red      = i_red;
            n_green    = i_green;
            n_blue     = i_blue;
            n_period   = PERIOD_BITS'(i_blink_period);
            n_phase    = 1'b0;
            n_level    = '0;
            n_falling  = 1'b0;
            n_tick     = '0;
            do_refresh = 1'b1;
        end else if (accept && (i_mode == rles_pkg::MODE_TICK) &&
                     (r_active == ACT_BLINK || r_active == ACT_BREATH)) begin
            // tick: count, refresh when the target or saturation is reached
            if ((CW'(cnt_inc) >= target) || (cnt_inc == CNT_MAX)) begin
                n_tick     = '0;
                do_refresh = 1'b1;
            end else begin
                n_tick = cnt_inc;
            end
        end

        if (do_refresh) begin
            unique case (e_active)
                ACT_OFF: begin
                    o_q_job = '0;
                end
                ACT_STATIC: begin
                    o_q_job.red   = n_red;
                    o_q_job.green = n_green;
                    o_q_job.blue  = n_blue;
                end
                ACT_BLINK: begin
                    if (e_phase) begin
                        o_q_job.red   = n_red;
                        o_q_job.green = n_green;
                        o_q_job.blue  = n_blue;
                    end
                    n_phase = !e_phase;
                end
                ACT_BREATH: begin
                    o_q_job.breath = 1'b1;
                    o_q_job.red    = n_red;
                    o_q_job.green  = n_green;
                    o_q_job.blue   = n_blue;
                    o_q_job.level  = br_level;
                    n_level        = br_level;
                    n_falling      = br_falling;
                end
                default: begin
                    o_q_job = '0;
                end
            endcase
        end
    end

    assign o_q_push = do_refresh;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= ACT_OFF;
            r_red     <= '0;
            r_green   <= '0;
            r_blue    <= '0;
            r_period  <= '0;
            r_phase   <= 1'b0;
            r_level   <= '0;
            r_falling <= 1'b0;
            r_tick    <= '0;
        end else begin
            r_active  <= n_active;
            r_red     <= n_red;
            r_green   <= n_green;
            r_blue    <= n_blue;
            r_period  <= n_period;
            r_phase   <= n_phase;
            r_level   <= n_level;
            r_falling <= n_falling;
            r_tick    <= n_tick;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_breath_step     <= rles_pkg::BREATH_STEP_RST;
            r_breath_interval <= rles_pkg::BREATH_INTERVAL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rles_pkg::CFG_BREATH_STEP: begin
                    r_breath_step <= i_cfg_data[rles_pkg::STEP_W-1:0];
                end
                rles_pkg::CFG_BREATH_INTERVAL: begin
                    r_breath_interval <= i_cfg_data[rles_pkg::INTV_W-1:0];
                end
                default: begin
                    r_breath_step <= r_breath_step;
                end
            endcase
        end
    end

endmodule

// ===== sv/rles_queue.sv =====
// Two-entry job queue between the front end and the back end.
module rles_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rles_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output rles_pkg::t_job  o_job
);

    rles_pkg::t_job r_entry [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== sv/rles_back.sv =====
// Back end: gamma and colour scaling on one shared multiplier, output register.
module rles_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // job queue pop side
    input  logic                         i_q_valid,
    input  rles_pkg::t_job               i_q_job,
    output logic                         o_q_pop,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rles_pkg::CHAN_W-1:0]  o_pixel_red,
    output logic [rles_pkg::CHAN_W-1:0]  o_pixel_green,
    output logic [rles_pkg::CHAN_W-1:0]  o_pixel_blue
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAM,
        S_RED,
        S_GRN,
        S_BLU,
        S_DONE
    } t_state;

    // x / 255 for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    t_state                      r_state;
    logic [rles_pkg::CHAN_W-1:0] r_cr, r_cg, r_cb, r_lvl, r_gam;
    logic [rles_pkg::CHAN_W-1:0] r_wr, r_wg, r_wb;
    logic [rles_pkg::CHAN_W-1:0] r_pr, r_pg, r_pb;
    logic                        r_out_valid;
    logic                        out_free;
    logic                        out_load;
    logic [rles_pkg::CHAN_W-1:0] mul_a, mul_b;
    logic [15:0]                 prod;
    logic [rles_pkg::CHAN_W-1:0] quot;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid && (i_q_job.breath || out_free);
    // a plain job or a finished breath job moves into the output register
    assign out_load = out_free &&
                      (((r_state == S_IDLE) && i_q_valid && !i_q_job.breath) ||
                       (r_state == S_DONE));

    // shared 8x8 multiplier operand select
    always_comb begin
        unique case (r_state)
            S_GAM: begin
                mul_a = r_lvl;
                mul_b = r_lvl;
            end
            S_RED: begin
                mul_a = r_cr;
                mul_b = r_gam;
            end
            S_GRN: begin
                mul_a = r_cg;
                mul_b = r_gam;
            end
            S_BLU: begin
                mul_a = r_cb;
                mul_b = r_gam;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign quot = div255(prod);

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_job.breath) begin
                            r_cr    <= i_q_job.red;
                            r_cg    <= i_q_job.green;
                            r_cb    <= i_q_job.blue;
                            r_lvl   <= i_q_job.level;
                            r_state <= S_GAM;
                        end else if (out_free) begin
                            r_pr <= i_q_job.red;
                            r_pg <= i_q_job.green;
                            r_pb <= i_q_job.blue;
                        end
                    end
                end
                S_GAM: begin
                    r_gam   <= quot;
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_wr    <= quot;
                    r_state <= S_GRN;
                end
                S_GRN: begin
                    r_wg    <= quot;
                    r_state <= S_BLU;
                end
                S_BLU: begin
                    r_wb    <= quot;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_pr    <= r_wr;
                        r_pg    <= r_wg;
                        r_pb    <= r_wb;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_red   = r_pr;
    assign o_pixel_green = r_pg;
    assign o_pixel_blue  = r_pb;

endmodule

// ===== sv/rgb_led_effect_sequencer.sv =====
// Top level of the RGB LED effect sequencer: front end, job queue, back end.
//
// Input channel (i_in_valid / o_in_ready): one transaction is either a
// millisecond tick (mode 0) or a command (1 off, 2 static, 3 blink, 4 breath)
// with a colour and a blink period. Modes 5 to 7 are taken and dropped.
// Output channel (o_out_valid / i_out_ready): one transaction per LED refresh.
// Configuration: i_cfg_we writes breath_step (index 0) or breath_interval
// (index 1) from i_cfg_data in the same cycle; write only while idle.
// The front end handles one transaction per cycle while the two-entry job
// queue has room. The back end takes a plain job (off, static, blink) every
// cycle while the output register is free; a breath job holds it through
// the pop, the gamma square and the three channel scalings sharing one 8x8
// multiplier, and the final load. Jobs pass the queue and output registers.
// When the receiver stalls, the result holds in the output register, the
// queue fills, and then o_in_ready drops until a result is taken.
// Reset (synchronous, active low) clears all effect state to off, empties
// the queue and output, and loads breath_step 5 and breath_interval 20.
module rgb_led_effect_sequencer #(
    parameter int unsigned PERIOD_BITS = rles_pkg::PERIOD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [rles_pkg::MODE_W-1:0]     i_mode,
    input  logic [rles_pkg::CHAN_W-1:0]     i_red,
    input  logic [rles_pkg::CHAN_W-1:0]     i_green,
    input  logic [rles_pkg::CHAN_W-1:0]     i_blue,
    input  logic [rles_pkg::BPER_W-1:0]     i_blink_period,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rles_pkg::CHAN_W-1:0]     o_pixel_red,
    output logic [rles_pkg::CHAN_W-1:0]     o_pixel_green,
    output logic [rles_pkg::CHAN_W-1:0]     o_pixel_blue,
    input  logic                            i_cfg_we,
    input  logic [rles_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rles_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    logic           q_full;
    logic           q_push;
    logic           q_valid;
    logic           q_pop;
    rles_pkg::t_job push_job;
    rles_pkg::t_job pop_job;

    rles_front #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_blink_period (i_blink_period),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_job        (push_job)
    );

    rles_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    rles_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_job       (pop_job),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_red   (o_pixel_red),
        .o_pixel_green (o_pixel_green),
        .o_pixel_blue  (o_pixel_blue)
    );

endmodule

// ===== tb/sv/led_refresh_checker.sv =====
// Checker for the RGB LED effect sequencer: predicts every LED refresh and compares it.
module led_refresh_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [rles_pkg::MODE_W-1:0]    i_mode,
    input  logic [rles_pkg::CHAN_W-1:0]    i_red,
    input  logic [rles_pkg::CHAN_W-1:0]    i_green,
    input  logic [rles_pkg::CHAN_W-1:0]    i_blue,
    input  logic [rles_pkg::BPER_W-1:0]    i_blink_period,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [rles_pkg::CHAN_W-1:0]    i_pixel_red,
    input  logic [rles_pkg::CHAN_W-1:0]    i_pixel_green,
    input  logic [rles_pkg::CHAN_W-1:0]    i_pixel_blue,
    input  logic                           i_cfg_we,
    input  logic [rles_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rles_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_refreshes
);
    timeunit 1ns;
    timeprecision 1ps;

    import rles_pkg::*;

    localparam int unsigned PBITS   = PERIOD_BITS_DEF;
    localparam int unsigned CNT_MAX = (32'd1 << PBITS) - 1;
    localparam int unsigned MAX_PRINTS = 50;

    // Effect currently running on the LED
    typedef enum logic [1:0] {
        FX_OFF,
        FX_STATIC,
        FX_BLINK,
        FX_BREATH
    } fx_e;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // Shadow of the effect state and the breath registers
    fx_e               fx_mode;
    logic [CHAN_W-1:0] col_r;
    logic [CHAN_W-1:0] col_g;
    logic [CHAN_W-1:0] col_b;
    logic [PBITS-1:0]  blink_per;
    logic              blink_lit;
    logic [CHAN_W-1:0] breath_lvl;
    logic              breath_down;
    logic [PBITS-1:0]  tick_cnt;
    logic [STEP_W-1:0] cfg_step;
    logic [INTV_W-1:0] cfg_intv;

    pixel_t expected_pixels[$];
    int     mismatches;
    int     refreshes;

    function automatic void report_mismatch(input string what, input int unsigned got,
                                            input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] refresh %0d: %s got %0d expected %0d",
                     $realtime, refreshes, what, got, want);
    endfunction

    function automatic void queue_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                        input logic [CHAN_W-1:0] b);
        pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        expected_pixels.push_back(px);
    endfunction

    function automatic void reset_state();
        fx_mode     = FX_OFF;
        col_r       = '0;
        col_g       = '0;
        col_b       = '0;
        blink_per   = '0;
        blink_lit   = 1'b0;
        breath_lvl  = '0;
        breath_down = 1'b0;
        tick_cnt    = '0;
        cfg_step    = BREATH_STEP_RST;
        cfg_intv    = BREATH_INTERVAL_RST;
        expected_pixels.delete();
    endfunction

    // One LED refresh in the running effect
    function automatic void refresh_led();
        int          lvl;
        int unsigned gam;
        case (fx_mode)
            FX_STATIC: queue_pixel(col_r, col_g, col_b);
            FX_BLINK: begin
                if (blink_lit)
                    queue_pixel(col_r, col_g, col_b);
                else
                    queue_pixel('0, '0, '0);
                blink_lit = ~blink_lit;
            end
            FX_BREATH: begin
                // triangle level, clamped at both ends where it turns around
                if (breath_down)
                    lvl = int'(breath_lvl) - int'(cfg_step);
                else
                    lvl = int'(breath_lvl) + int'(cfg_step);
                if (lvl >= 255) begin
                    lvl         = 255;
                    breath_down = 1'b1;
                end else if (lvl <= 0) begin
                    lvl         = 0;
                    breath_down = 1'b0;
                end
                breath_lvl = 8'(lvl);
                gam = (lvl * lvl) / 255;
                queue_pixel(8'((col_r * gam) / 255), 8'((col_g * gam) / 255),
                            8'((col_b * gam) / 255));
            end
            default: queue_pixel('0, '0, '0);
        endcase
    endfunction

    // Expected refresh, if any, caused by one accepted input transaction
    function automatic void predict_refresh(input logic [MODE_W-1:0] mode,
                                            input logic [CHAN_W-1:0] r,
                                            input logic [CHAN_W-1:0] g,
                                            input logic [CHAN_W-1:0] b,
                                            input logic [BPER_W-1:0] per);
        int unsigned target;
        if (mode == MODE_TICK) begin
            if (fx_mode == FX_BLINK)
                target = blink_per;
            else if (fx_mode == FX_BREATH)
                target = cfg_intv;
            else
                return;
            // counter saturates, and a saturated counter always steps
            if (tick_cnt < CNT_MAX)
                tick_cnt++;
            if (tick_cnt < target && tick_cnt < CNT_MAX)
                return;
            tick_cnt = '0;
            refresh_led();
            return;
        end
        case (mode)
            MODE_OFF:    fx_mode = FX_OFF;
            MODE_STATIC: fx_mode = FX_STATIC;
            MODE_BLINK:  fx_mode = FX_BLINK;
            MODE_BREATH: fx_mode = FX_BREATH;
            default:     return; // unknown codes are dropped
        endcase
        col_r       = r;
        col_g       = g;
        col_b       = b;
        blink_per   = PBITS'(per);
        blink_lit   = 1'b0;
        breath_lvl  = '0;
        breath_down = 1'b0;
        tick_cnt    = '0;
        refresh_led();
    endfunction

    function automatic void check_pixel();
        pixel_t want;
        refreshes++;
        if (expected_pixels.size() == 0) begin
            report_mismatch("refresh with nothing pending, red", i_pixel_red, 0);
            return;
        end
        want = expected_pixels.pop_front();
        if (i_pixel_red !== want.red)
            report_mismatch("red", i_pixel_red, want.red);
        if (i_pixel_green !== want.green)
            report_mismatch("green", i_pixel_green, want.green);
        if (i_pixel_blue !== want.blue)
            report_mismatch("blue", i_pixel_blue, want.blue);
    endfunction

    // Watch both channels and the register port at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_state();
        end else begin
            if (i_out_valid && i_out_ready)
                check_pixel();
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BREATH_STEP)
                    cfg_step = i_cfg_data[STEP_W-1:0];
                else if (i_cfg_idx == CFG_BREATH_INTERVAL)
                    cfg_intv = i_cfg_data[INTV_W-1:0];
            end
            if (i_in_valid && i_in_ready)
                predict_refresh(i_mode, i_red, i_green, i_blue, i_blink_period);
        end
        o_errors    <= mismatches;
        o_pending   <= expected_pixels.size();
        o_refreshes <= refreshes;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the RGB LED effect sequencer: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rles_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES  = 12;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned N_PHASES       = 5;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [MODE_W-1:0]    i_mode;
    logic [CHAN_W-1:0]    i_red;
    logic [CHAN_W-1:0]    i_green;
    logic [CHAN_W-1:0]    i_blue;
    logic [BPER_W-1:0]    i_blink_period;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [CHAN_W-1:0]    o_pixel_red;
    logic [CHAN_W-1:0]    o_pixel_green;
    logic [CHAN_W-1:0]    o_pixel_blue;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    int chk_errors;
    int chk_pending;
    int chk_refreshes;

    // Breath register settings visited after the reset defaults
    int unsigned step_set[N_PHASES] = '{1, 255, 0, 128, 37};
    int unsigned intv_set[N_PHASES] = '{1, 1, 0, 3, 7};

    // Sender bookkeeping
    bit                tx_burst;
    bit                tx_steady;
    int unsigned       tx_seg_left;
    int unsigned       n_cmds;
    int unsigned       n_ticks;
    int unsigned       n_dropped;
    int unsigned       n_settings;

    // Long receiver hold-off requests
    int unsigned hold_requests;
    int unsigned holds_done;

    rgb_led_effect_sequencer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_blink_period (i_blink_period),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_red    (o_pixel_red),
        .o_pixel_green  (o_pixel_green),
        .o_pixel_blue   (o_pixel_blue),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    led_refresh_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_blink_period (i_blink_period),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_pixel_red    (o_pixel_red),
        .i_pixel_green  (o_pixel_green),
        .i_pixel_blue   (o_pixel_blue),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (chk_errors),
        .o_pending      (chk_pending),
        .o_refreshes    (chk_refreshes)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Colour channel, biased toward the extremes
    function automatic logic [CHAN_W-1:0] pick_chan();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return 8'($urandom);
    endfunction

    // Offer one input transaction, after an optional gap, and wait until it is taken
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] red,
                             input logic [CHAN_W-1:0] grn, input logic [CHAN_W-1:0] blu,
                             input logic [BPER_W-1:0] per);
        int unsigned gap;
        int unsigned roll;
        gap = 0;
        if (!tx_burst) begin
            if (tx_seg_left == 0) begin
                tx_seg_left = $urandom_range(10, 80);
                tx_steady   = ($urandom_range(0, 3) == 0);
            end
            tx_seg_left--;
            if (!tx_steady) begin
                roll = $urandom_range(0, 99);
                if (roll >= 90)
                    gap = $urandom_range(10, 60);
                else if (roll >= 60)
                    gap = $urandom_range(1, 3);
            end
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_red          <= red;
        i_green        <= grn;
        i_blue         <= blu;
        i_blink_period <= per;
        do @(posedge i_clk); while (!o_in_ready);
        if (mode == MODE_TICK) begin
            n_ticks++;
        end else if (mode > MODE_BREATH) begin
            n_dropped++;
        end else begin
            n_cmds++;
        end
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_item(MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    endtask

    // Stop offering and wait until every expected refresh has arrived
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DAT_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random sequences: a command followed by a burst of ticks, with some noise
    task automatic run_random(input int unsigned n);
        int unsigned       done;
        int unsigned       roll;
        int unsigned       burst;
        logic [MODE_W-1:0] m;
        logic [BPER_W-1:0] per;
        done = 0;
        while (done < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                m = MODE_BLINK;
            else if (roll < 80)
                m = MODE_BREATH;
            else if (roll < 90)
                m = MODE_STATIC;
            else
                m = MODE_OFF;
            roll = $urandom_range(0, 99);
            if (roll < 70)
                per = 16'($urandom_range(0, 6));
            else if (roll < 90)
                per = 16'($urandom_range(7, 40));
            else
                per = 16'($urandom);
            send_item(m, pick_chan(), pick_chan(), pick_chan(), per);
            done++;
            burst = $urandom_range(0, 24);
            repeat (burst) begin
                if ($urandom_range(0, 99) < 4) begin
                    send_item(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom),
                              8'($urandom), 16'($urandom));
                end else begin
                    send_ticks(1);
                end
                done++;
            end
        end
    endtask

    // Receiver: random stalls, steady stretches, and the long hold-off on request
    initial begin
        int unsigned stall_left;
        int unsigned seg_left;
        bit          steady;
        stall_left  = 0;
        seg_left    = 0;
        steady      = 1'b0;
        holds_done  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (seg_left == 0) begin
                seg_left = $urandom_range(40, 300);
                steady   = ($urandom_range(0, 3) == 0);
            end
            seg_left--;
            if (stall_left != 0) begin
                stall_left--;
            end else if (holds_done < hold_requests) begin
                holds_done++;
                stall_left = LONG_HOLD;
            end else if (!steady && $urandom_range(0, 99) < 30) begin
                if ($urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(10, 50);
                else
                    stall_left = $urandom_range(1, 3);
            end
            i_out_ready <= (stall_left == 0);
        end
    end

    // Watchdog: too long without any transaction on either channel
    initial begin
        int unsigned idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("[%0t] no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("rgb_led_effect_sequencer verification failed");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_mode         = MODE_TICK;
        i_red          = '0;
        i_green        = '0;
        i_blue         = '0;
        i_blink_period = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_BREATH_STEP;
        i_cfg_data     = '0;
        tx_burst       = 1'b0;
        tx_steady      = 1'b0;
        tx_seg_left    = 0;
        n_cmds         = 0;
        n_ticks        = 0;
        n_dropped      = 0;
        n_settings     = 1;
        hold_requests  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: dropped codes, ticks with nothing running, each command
        send_ticks(1);
        send_item(3'd5, 8'hFF, 8'h00, 8'hFF, 16'hFFFF);
        send_item(3'd6, 8'h00, 8'hFF, 8'h00, 16'h0000);
        send_item(3'd7, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
        send_item(MODE_OFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_item(MODE_STATIC, 8'hFF, 8'h00, 8'hFF, 16'h0000);
        send_item(MODE_STATIC, 8'h00, 8'hFF, 8'h00, 16'h5555);
        send_ticks(1);
        // blink with period zero steps on every tick
        send_item(MODE_BLINK, 8'hFF, 8'h80, 8'h01, 16'h0000);
        send_ticks(3);
        send_item(MODE_BLINK, 8'h11, 8'h22, 8'h33, 16'h0002);
        send_ticks(4);
        send_item(MODE_BREATH, 8'hFF, 8'hFF, 8'hFF, 16'hAAAA);
        send_item(MODE_OFF, 8'h00, 8'h00, 8'h00, 16'h0000);

        // Random with the reset register values
        run_random(220);

        // Random over several breath settings, zero step and interval among them
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            cfg_write(CFG_BREATH_STEP, step_set[p]);
            cfg_write(CFG_BREATH_INTERVAL, intv_set[p]);
            n_settings++;
            if (p == 0)
                hold_requests++;
            run_random(180);
        end

        // Slow effects back to back: a long breath interval and a long blink period
        settle();
        cfg_write(CFG_BREATH_STEP, 255);
        cfg_write(CFG_BREATH_INTERVAL, 50);
        n_settings++;
        tx_burst = 1'b1;
        send_item(MODE_BREATH, 8'hC0, 8'h40, 8'hFF, 16'h0001);
        send_ticks(50);
        send_item(MODE_BLINK, 8'hFF, 8'hFF, 8'hFF, 16'd40);
        send_ticks(40);
        tx_burst = 1'b0;
        settle();

        $display("Sent %0d transactions: %0d commands, %0d ticks, %0d dropped codes",
                 n_cmds + n_ticks + n_dropped, n_cmds, n_ticks, n_dropped);
        $display("Checked %0d LED refreshes over %0d breath register settings",
                 chk_refreshes, n_settings);
        if (chk_errors == 0 && chk_pending == 0)
            $display("rgb_led_effect_sequencer verification clean");
        else
            $display("rgb_led_effect_sequencer verification failed");
        $finish;
    end

endmodule
